[design/crc16fc_pkg.sv]
// ----------------------------------------------------------------------------
// crc16fc_pkg
// Shared types and CRC-16 helpers for the frame checker.
// ----------------------------------------------------------------------------
package crc16fc_pkg;

	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'h0000;
	localparam int          BYTE_W    = 8;
	localparam int          CRC_W     = 16;

	// one received word as it moves from the input register to the core
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              is_check_byte;
	} item_t;

	// reflected CRC update, one byte, eight unrolled shift steps
	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
	                                              input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] mirror8(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int k = 0; k < BYTE_W; k++) begin
			r[k] = v[BYTE_W-1-k];
		end
		return r;
	endfunction

endpackage

[design/crc16fc_in_reg.sv]
// ----------------------------------------------------------------------------
// crc16fc_in_reg
// Input register stage: captures one word per cycle from the slave side while in_ready is high.
// ----------------------------------------------------------------------------
module crc16fc_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  crc16fc_pkg::item_t  in_item,
	output logic                valid_s1,
	output crc16fc_pkg::item_t  item_s1,
	input  logic                take
);

	logic               vld_s1;
	crc16fc_pkg::item_t itm_s1;

	// refill in the same cycle the core drains the stage
	assign in_ready = !vld_s1 || take;
	assign valid_s1 = vld_s1;
	assign item_s1  = itm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			itm_s1 <= in_item;
		end
	end

endmodule

[design/crc16fc_core.sv]
// ----------------------------------------------------------------------------
// crc16fc_core
// Frame state (running CRC, check byte tracking) and the result register.
// ----------------------------------------------------------------------------
module crc16fc_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid_s1,
	input  crc16fc_pkg::item_t                   item_s1,
	output logic                                 take,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 frame_ok,
	output logic [crc16fc_pkg::CRC_W-1:0]        computed_crc
);

	logic [crc16fc_pkg::CRC_W-1:0]  crc_q;
	logic                           seen_q;
	logic                           lo_ok_q;
	logic                           out_valid_q;
	logic                           frame_ok_q;
	logic [crc16fc_pkg::CRC_W-1:0]  crc_out_q;

	logic                           res_free;
	logic                           final_chk;
	logic [crc16fc_pkg::BYTE_W-1:0] exp_byte;
	logic                           byte_match;

	assign res_free  = !out_valid_q || out_ready;
	assign take      = valid_s1 && res_free;
	assign final_chk = item_s1.is_check_byte && seen_q;

	// low check byte first, then high
	assign exp_byte   = seen_q ? crc16fc_pkg::mirror8(crc_q[15:8])
	                           : crc16fc_pkg::mirror8(crc_q[7:0]);
	assign byte_match = (item_s1.data_byte == exp_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= crc16fc_pkg::CRC_INIT;
			seen_q      <= 1'b0;
			lo_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && final_chk) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (!item_s1.is_check_byte) begin
					crc_q   <= crc16fc_pkg::crc_fold(crc_q, item_s1.data_byte);
					seen_q  <= 1'b0;
					lo_ok_q <= 1'b0;
				end else if (!seen_q) begin
					seen_q  <= 1'b1;
					lo_ok_q <= byte_match;
				end else begin
					crc_q       <= crc16fc_pkg::CRC_INIT;
					seen_q      <= 1'b0;
					lo_ok_q     <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && final_chk) begin
			frame_ok_q <= lo_ok_q && byte_match;
			crc_out_q  <= crc_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_ok     = frame_ok_q;
	assign computed_crc = crc_out_q;

`ifndef ASSERT_OFF
	a_final_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(take && final_chk) |=> out_valid_q)
		else $error("final check word did not produce a result");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && final_chk) |=> (crc_q == crc16fc_pkg::CRC_INIT && !seen_q && !lo_ok_q))
		else $error("frame state not cleared after result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !take)
		else $error("pending result overwritten");

	a_payload_drops_check: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !item_s1.is_check_byte) |=> (!seen_q && !lo_ok_q))
		else $error("payload word left check tracking set");
`endif

endmodule

[design/crc16_frame_checker.sv]
// ----------------------------------------------------------------------------
// crc16_frame_checker
// CRC-16/ARC frame checker: payload words fold into the CRC, two trailing
// check words (low first, bit-reversed) are compared, one verdict per frame.
// ----------------------------------------------------------------------------
// Result path: the last check word passes the input register, then the result
//   register, before m_tvalid rises.
// Throughput: one word per cycle while no result waits; the input register and the result register
//   let a new word enter while a result waits, the CRC update is one unrolled
//   byte step between them.
// Reset: arst_n clears the running CRC, the check word tracking and both
//   valid flags; no warm-up is needed.
module crc16_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] is_check_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] computed_crc
	output logic        m_tuser    // [0] frame_ok
);

	crc16fc_pkg::item_t in_item;
	crc16fc_pkg::item_t item_s1;
	logic               valid_s1;
	logic               take;

	assign in_item.data_byte     = s_tdata;
	assign in_item.is_check_byte = s_tuser;

	crc16fc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take)
	);

	crc16fc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.take         (take),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.frame_ok     (m_tuser),
		.computed_crc (m_tdata)
	);

endmodule

[tb/crc16_frame_checker_tb.sv]
// ----------------------------------------------------------------------------
// crc16_frame_checker testbench
// Streams frames of payload and check words into the checker, predicts each
// frame verdict and CRC on the side, and compares every result word in order.
// Both handshake sides stall at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int TOTAL_WORDS  = 1100;
	localparam int DRAIN_CYCLES = 8;

	typedef logic [crc16fc_pkg::BYTE_W-1:0] byte_t;
	typedef logic [crc16fc_pkg::CRC_W-1:0]  crc_t;

	typedef struct packed {
		logic ok;
		crc_t crc;
	} verdict_t;

	typedef enum int {CHK_GOOD, CHK_BAD_LO, CHK_BAD_HI, CHK_BAD_BOTH} check_mode_t;

	// tracks the frame in flight and holds the verdicts not yet seen on the output
	class crc16_verdict_board;
		crc_t     running_crc;
		bit       first_seen;
		bit       first_ok;
		verdict_t pending_verdicts[$];
		int       fail_count;

		function new();
			running_crc = crc16fc_pkg::CRC_INIT;
			first_seen  = 1'b0;
			first_ok    = 1'b0;
			fail_count  = 0;
		endfunction

		static function crc_t fold(crc_t c, byte_t b);
			c = c ^ {{(crc16fc_pkg::CRC_W-crc16fc_pkg::BYTE_W){1'b0}}, b};
			repeat (crc16fc_pkg::BYTE_W) begin
				c = c[0] ? ((c >> 1) ^ crc16fc_pkg::CRC_POLY) : (c >> 1);
			end
			return c;
		endfunction

		static function byte_t mirror(byte_t b);
			return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
		endfunction

		function byte_t good_check(bit high_half);
			return mirror(high_half ? running_crc[15:8] : running_crc[7:0]);
		endfunction

		function void note_word(byte_t b, logic is_check);
			verdict_t v;
			if (!is_check) begin
				running_crc = fold(running_crc, b);
				first_seen  = 1'b0;
				first_ok    = 1'b0;
			end else if (!first_seen) begin
				first_ok   = (b == mirror(running_crc[7:0]));
				first_seen = 1'b1;
			end else begin
				v.ok  = first_ok && (b == mirror(running_crc[15:8]));
				v.crc = running_crc;
				pending_verdicts.push_back(v);
				running_crc = crc16fc_pkg::CRC_INIT;
				first_seen  = 1'b0;
				first_ok    = 1'b0;
			end
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			fail_count++;
		endtask

		task check_verdict(crc_t crc, logic ok);
			verdict_t v;
			if (pending_verdicts.size() == 0) begin
				report($sformatf("unexpected result word crc=%h ok=%b", crc, ok));
			end else begin
				v = pending_verdicts.pop_front();
				if (crc !== v.crc) begin
					report($sformatf("computed_crc got %h want %h", crc, v.crc));
				end
				if (ok !== v.ok) begin
					report($sformatf("frame_ok got %b want %b (crc %h)", ok, v.ok, v.crc));
				end
			end
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  s_tvalid;
	logic  s_tready;
	byte_t s_tdata;   // [7:0] data_byte
	logic  s_tuser;   // [0] is_check_byte
	logic  m_tvalid;
	logic  m_tready;
	crc_t  m_tdata;   // [15:0] computed_crc
	logic  m_tuser;   // [0] frame_ok

	crc16_verdict_board board;
	bit idle_on;
	int words_sent;
	int cycle_count = 0;

	crc16_frame_checker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_verdict(m_tdata, m_tuser);
		end
	end

	// mostly no gap, sometimes a short gap, rarely a long pause; no gap while idle_on is clear
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	initial begin : ready_gen
		int stall_left;
		int r;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				r = $urandom_range(0, 99);
				if (idle_on && r < 20) begin
					stall_left = $urandom_range(1, 3);
				end else if (idle_on && r < 23) begin
					stall_left = $urandom_range(10, 40);
				end
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input byte_t b, input logic is_check);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tuser  = is_check;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_word(b, is_check);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input int payload_len, input check_mode_t mode);
		byte_t lo;
		byte_t hi;
		repeat (payload_len) send_word(byte_t'($urandom), 1'b0);
		lo = board.good_check(1'b0);
		hi = board.good_check(1'b1);
		if (mode == CHK_BAD_LO || mode == CHK_BAD_BOTH) begin
			lo = lo ^ byte_t'($urandom_range(1, 255));
		end
		if (mode == CHK_BAD_HI || mode == CHK_BAD_BOTH) begin
			hi = hi ^ byte_t'($urandom_range(1, 255));
		end
		send_word(lo, 1'b1);
		send_word(hi, 1'b1);
	endtask

	initial begin
		int r;
		int len;
		check_mode_t mode;
		board      = new();
		words_sent = 0;
		idle_on    = 1'b1;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty frame right after reset: good, then with a bad low check word
		send_word(8'h00, 1'b1);
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b1);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_frame(0, CHK_GOOD);
		// lone check word followed by payload: the check word is dropped
		send_word(8'h5A, 1'b0);
		send_word(8'h3C, 1'b1);
		send_word(8'hA5, 1'b0);
		send_frame(0, CHK_GOOD);
		send_word(8'h80, 1'b0);
		send_frame(0, CHK_BAD_LO);
		send_word(8'h01, 1'b0);
		send_frame(0, CHK_BAD_HI);
		send_word(8'h7F, 1'b0);
		send_frame(0, CHK_BAD_BOTH);

		while (words_sent < TOTAL_WORDS) begin
			idle_on = ((words_sent / 100) % 4) != 3;
			r = $urandom_range(0, 99);
			if (r < 85) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
				                                  : $urandom_range(0, 12);
				r = $urandom_range(0, 9);
				mode = (r < 6) ? CHK_GOOD : (r < 7) ? CHK_BAD_LO
				     : (r < 8) ? CHK_BAD_HI : CHK_BAD_BOTH;
				send_frame(len, mode);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_word(byte_t'($urandom), logic'($urandom_range(0, 1)));
				end
			end
		end
		s_tvalid = 1'b0;
		idle_on  = 1'b1;

		while (board.pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
